// ===== design/lobm_pkg.sv =====
// Shared types and codes of the limit order book matcher.
package lobm_pkg;

   // Book size default and entry index width (covers books of up to 64 entries)
   localparam int MAX_ORDERS_DEF = 32;
   localparam int IDX_W          = 6;

   // Commands; the unused code is ignored
   localparam logic [1:0] CMD_NEW    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Time in force
   localparam logic [1:0] TIF_IOC = 2'd1;
   localparam logic [1:0] TIF_FOK = 2'd2;

   // Report kinds
   localparam logic [1:0] KIND_FILL     = 2'd0;
   localparam logic [1:0] KIND_OWN      = 2'd1;
   localparam logic [1:0] KIND_NOTFOUND = 2'd2;

   // Order status
   localparam logic [2:0] ST_NEW       = 3'd0;
   localparam logic [2:0] ST_PARTIAL   = 3'd1;
   localparam logic [2:0] ST_FILLED    = 3'd2;
   localparam logic [2:0] ST_CANCELLED = 3'd3;
   localparam logic [2:0] ST_REJECTED  = 3'd4;

   // Entry update operations
   localparam logic [1:0] UPD_NONE = 2'd0;
   localparam logic [1:0] UPD_FILL = 2'd1;
   localparam logic [1:0] UPD_KILL = 2'd2;
   localparam logic [1:0] UPD_REST = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;

   // Search terms broadcast to every cell
   typedef struct packed {
      logic        side;
      logic        market;
      logic [31:0] limit;
      logic [31:0] target;
      logic [31:0] now;
   } scan_type;

   // Write to one entry of the book
   typedef struct packed {
      logic [1:0]  op;
      idx_type     idx;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] leaves;
      logic [31:0] oid;
      logic [31:0] cid;
      logic [31:0] arrival;
   } upd_type;

   // Running search result handed from cell to cell
   typedef struct packed {
      logic              best_vld;
      idx_type           best_idx;
      logic [31:0]       best_price;
      logic [31:0]       best_age;
      logic [31:0]       best_qty;
      logic [31:0]       best_leaves;
      logic [31:0]       best_oid;
      logic [31:0]       best_cid;
      logic [IDX_W+31:0] avail;
      logic              tgt_vld;
      idx_type           tgt_idx;
      logic              tgt_side;
      logic [31:0]       tgt_qty;
      logic [31:0]       tgt_leaves;
      logic [31:0]       tgt_cid;
      logic              free_vld;
      idx_type           free_idx;
   } cand_type;

   // One report
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] oid;
      logic [31:0] cid;
      logic [2:0]  status;
      logic [31:0] cum;
      logic [31:0] leaves;
      logic [31:0] lp;
      logic [31:0] lq;
      logic [31:0] tid;
      logic [31:0] coid;
      logic [31:0] ccid;
      logic        last;
   } rpt_type;

endpackage

// ===== design/lobm_cell.sv =====
// One book entry with its stage of the best-order / id / free-slot search chain.
module lobm_cell (
   input  logic               clock,
   input  logic               reset,
   input  lobm_pkg::idx_type  cell_idx,
   input  lobm_pkg::scan_type scan,
   input  lobm_pkg::upd_type  upd,
   input  lobm_pkg::cand_type cand_in,
   output lobm_pkg::cand_type cand_out
);
   import lobm_pkg::*;

   logic        valid_ff;
   logic        side_ff;
   logic [31:0] price_ff, qty_ff, leaves_ff, oid_ff, cid_ff, arrival_ff;
   cand_type    cand_ff, cand_in_c;

   logic        elig, better;
   logic [31:0] age;

   // Apply entry updates addressed to this cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (upd.idx == cell_idx) begin
         case (upd.op)
            UPD_FILL: begin
               leaves_ff <= upd.leaves;
               valid_ff  <= |upd.leaves;
            end
            UPD_KILL: valid_ff <= 1'b0;
            UPD_REST: begin
               valid_ff   <= 1'b1;
               side_ff    <= upd.side;
               price_ff   <= upd.price;
               qty_ff     <= upd.quantity;
               leaves_ff  <= upd.leaves;
               oid_ff     <= upd.oid;
               cid_ff     <= upd.cid;
               arrival_ff <= upd.arrival;
            end
            default: ;
         endcase
      end
   end

   // Fold this entry into the running search result
   always_comb begin
      age  = scan.now - arrival_ff;
      elig = valid_ff && (side_ff != scan.side) &&
             (scan.market || (scan.side == 1'b0 ? price_ff <= scan.limit
                                                 : price_ff >= scan.limit));
      if (!cand_in.best_vld)
         better = 1'b1;
      else if (scan.side == 1'b0 ? price_ff < cand_in.best_price
                                 : price_ff > cand_in.best_price)
         better = 1'b1;
      else
         better = (price_ff == cand_in.best_price) && (age > cand_in.best_age);

      cand_in_c = cand_in;
      if (elig) begin
         cand_in_c.avail = cand_in.avail + {{IDX_W{1'b0}}, leaves_ff};
         if (better) begin
            cand_in_c.best_vld    = 1'b1;
            cand_in_c.best_idx    = cell_idx;
            cand_in_c.best_price  = price_ff;
            cand_in_c.best_age    = age;
            cand_in_c.best_qty    = qty_ff;
            cand_in_c.best_leaves = leaves_ff;
            cand_in_c.best_oid    = oid_ff;
            cand_in_c.best_cid    = cid_ff;
         end
      end
      if (!cand_in.tgt_vld && valid_ff && oid_ff == scan.target) begin
         cand_in_c.tgt_vld    = 1'b1;
         cand_in_c.tgt_idx    = cell_idx;
         cand_in_c.tgt_side   = side_ff;
         cand_in_c.tgt_qty    = qty_ff;
         cand_in_c.tgt_leaves = leaves_ff;
         cand_in_c.tgt_cid    = cid_ff;
      end
      if (!cand_in.free_vld && !valid_ff) begin
         cand_in_c.free_vld = 1'b1;
         cand_in_c.free_idx = cell_idx;
      end
   end

   // Hand the result to the next cell
   always_ff @(posedge clock) begin
      cand_ff <= cand_in_c;
   end

   assign cand_out = cand_ff;

endmodule

// ===== design/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: command control, counters and cell chain.
//
// The book is a chain of MAX_ORDERS cells; each search result ripples through the
// chain one cell per cycle, so every decision waits for a result that has passed
// through the whole chain. A cancel, a modify or a new order that makes no trade
// holds the input through the accepting cycle, the search and a decision step that
// loads the report. Each fill loads a fill report and starts a new search before the
// next decision. An unknown command gives no report. Reports leave through an output
// register, so a stalled result channel holds the block only when a further report
// must be loaded, one cycle per stalled cycle. Input is taken only while no command is
// in progress. symbol_index is stored and read back only.
module limit_order_book_matcher #(
   parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic        req_side,
   input  logic        req_order_kind,
   input  logic [1:0]  req_time_in_force,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   input  logic [31:0] req_client_order_id,
   input  logic [31:0] req_target_order_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_report_kind,
   output logic [31:0] rsp_order_id,
   output logic [31:0] rsp_report_client_id,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_cum_qty,
   output logic [31:0] rsp_leaves_qty,
   output logic [31:0] rsp_last_price,
   output logic [31:0] rsp_last_qty,
   output logic [31:0] rsp_trade_id,
   output logic [31:0] rsp_counter_order_id,
   output logic [31:0] rsp_counter_client_id,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lobm_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WAIT   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  cmd_ff;
   logic        side_ff, market_ff;
   logic [1:0]  tif_ff;
   logic [31:0] price_ff, qty_ff, cid_ff, target_ff;
   logic [31:0] oid_ff, oid_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        first_ff, first_in;
   logic [31:0] next_order_ff, next_order_in;
   logic [31:0] next_trade_ff, next_trade_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [15:0] symbol_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rpt_type     rpt_ff, rpt_in;
   logic        load_rpt;

   scan_type    scan;
   upd_type     upd;
   cand_type    chain [MAX_ORDERS+1];
   cand_type    tail;

   logic        req_xfer, out_ok;
   logic [31:0] traded, lv, cum;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'd0, symbol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_ff <= 16'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         symbol_ff <= csr_pwdata[15:0];
      end
   end

   // Cell chain
   assign chain[0] = '0;
   assign scan     = '{side: side_ff, market: market_ff, limit: price_ff,
                       target: target_ff, now: arrival_ff};

   for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
      lobm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .scan     (scan),
         .upd      (upd),
         .cand_in  (chain[i]),
         .cand_out (chain[i+1])
      );
   end

   assign tail = chain[MAX_ORDERS];

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_ok    = !rsp_valid_ff || !rsp_stall;

   // Command control
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      oid_in        = oid_ff;
      remaining_in  = remaining_ff;
      first_in      = first_ff;
      next_order_in = next_order_ff;
      next_trade_in = next_trade_ff;
      arrival_in    = arrival_ff;
      rpt_in        = '0;
      rpt_in.last   = 1'b1;
      load_rpt      = 1'b0;
      upd           = '0;
      upd.op        = UPD_NONE;

      traded = (remaining_ff < tail.best_leaves) ? remaining_ff : tail.best_leaves;
      lv     = tail.best_leaves - traded;
      cum    = qty_ff - remaining_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_cmd != CMD_NONE) begin
               state_in     = S_WAIT;
               cnt_in       = IDX_W'(MAX_ORDERS);
               remaining_in = req_quantity;
               first_in     = 1'b1;
               if (req_cmd == CMD_NEW) begin
                  oid_in        = next_order_ff;
                  next_order_in = next_order_ff + 32'd1;
               end
            end
         end
         S_WAIT: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == IDX_W'(1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (out_ok) begin
               load_rpt = 1'b1;
               state_in = S_IDLE;
               if (cmd_ff == CMD_NEW) begin
                  rpt_in.kind = KIND_OWN;
                  rpt_in.oid  = oid_ff;
                  rpt_in.cid  = cid_ff;
                  if (first_ff && tif_ff == TIF_FOK &&
                      tail.avail < {{IDX_W{1'b0}}, qty_ff}) begin
                     rpt_in.status = ST_REJECTED;
                     rpt_in.leaves = qty_ff;
                  end else if (remaining_ff != 32'd0 && tail.best_vld) begin
                     // trade against the best resting order
                     rpt_in.kind   = KIND_FILL;
                     rpt_in.oid    = tail.best_oid;
                     rpt_in.cid    = tail.best_cid;
                     rpt_in.status = (lv == 32'd0) ? ST_FILLED : ST_PARTIAL;
                     rpt_in.cum    = tail.best_qty - lv;
                     rpt_in.leaves = lv;
                     rpt_in.lp     = tail.best_price;
                     rpt_in.lq     = traded;
                     rpt_in.tid    = next_trade_ff;
                     rpt_in.coid   = oid_ff;
                     rpt_in.ccid   = cid_ff;
                     rpt_in.last   = 1'b0;
                     next_trade_in = next_trade_ff + 32'd1;
                     remaining_in  = remaining_ff - traded;
                     first_in      = 1'b0;
                     upd.op        = UPD_FILL;
                     upd.idx       = tail.best_idx;
                     upd.leaves    = lv;
                     state_in      = S_WAIT;
                     cnt_in        = IDX_W'(MAX_ORDERS);
                  end else if (remaining_ff == 32'd0) begin
                     rpt_in.status = ST_FILLED;
                     rpt_in.cum    = qty_ff;
                  end else if (market_ff || tif_ff == TIF_IOC) begin
                     rpt_in.status = ST_CANCELLED;
                     rpt_in.cum    = cum;
                  end else if (!tail.free_vld) begin
                     rpt_in.status = ST_REJECTED;
                     rpt_in.cum    = cum;
                  end else begin
                     // rest the remainder in the first free entry
                     rpt_in.status = (cum != 32'd0) ? ST_PARTIAL : ST_NEW;
                     rpt_in.cum    = cum;
                     rpt_in.leaves = remaining_ff;
                     upd.op        = UPD_REST;
                     upd.idx       = tail.free_idx;
                     upd.side      = side_ff;
                     upd.price     = price_ff;
                     upd.quantity  = qty_ff;
                     upd.leaves    = remaining_ff;
                     upd.oid       = oid_ff;
                     upd.cid       = cid_ff;
                     upd.arrival   = arrival_ff;
                     arrival_in    = arrival_ff + 32'd1;
                  end
               end else if (!tail.tgt_vld) begin
                  rpt_in.kind   = KIND_NOTFOUND;
                  rpt_in.oid    = target_ff;
                  rpt_in.status = ST_REJECTED;
               end else if (cmd_ff == CMD_CANCEL || qty_ff == 32'd0) begin
                  rpt_in.kind   = KIND_OWN;
                  rpt_in.oid    = target_ff;
                  rpt_in.cid    = tail.tgt_cid;
                  rpt_in.status = ST_CANCELLED;
                  rpt_in.cum    = tail.tgt_qty - tail.tgt_leaves;
                  upd.op        = UPD_KILL;
                  upd.idx       = tail.tgt_idx;
               end else begin
                  // replace in place, keeping the original side
                  rpt_in.kind   = KIND_OWN;
                  rpt_in.oid    = next_order_ff;
                  rpt_in.cid    = tail.tgt_cid;
                  rpt_in.status = ST_NEW;
                  rpt_in.leaves = qty_ff;
                  upd.op        = UPD_REST;
                  upd.idx       = tail.tgt_idx;
                  upd.side      = tail.tgt_side;
                  upd.price     = price_ff;
                  upd.quantity  = qty_ff;
                  upd.leaves    = qty_ff;
                  upd.oid       = next_order_ff;
                  upd.cid       = tail.tgt_cid;
                  upd.arrival   = arrival_ff;
                  next_order_in = next_order_ff + 32'd1;
                  arrival_in    = arrival_ff + 32'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load_rpt)
         rsp_valid_in = 1'b1;
      else if (rsp_stall)
         rsp_valid_in = rsp_valid_ff;
      else
         rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         next_order_ff <= 32'd1;
         next_trade_ff <= 32'd1;
         arrival_ff    <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         next_order_ff <= next_order_in;
         next_trade_ff <= next_trade_in;
         arrival_ff    <= arrival_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Command and report payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff    <= req_cmd;
         side_ff   <= req_side;
         market_ff <= req_order_kind;
         tif_ff    <= req_time_in_force;
         price_ff  <= req_price;
         qty_ff    <= req_quantity;
         cid_ff    <= req_client_order_id;
         target_ff <= req_target_order_id;
      end
      oid_ff       <= oid_in;
      remaining_ff <= remaining_in;
      first_ff     <= first_in;
      if (load_rpt) rpt_ff <= rpt_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_report_kind       = rpt_ff.kind;
   assign rsp_order_id          = rpt_ff.oid;
   assign rsp_report_client_id  = rpt_ff.cid;
   assign rsp_status            = rpt_ff.status;
   assign rsp_cum_qty           = rpt_ff.cum;
   assign rsp_leaves_qty        = rpt_ff.leaves;
   assign rsp_last_price        = rpt_ff.lp;
   assign rsp_last_qty          = rpt_ff.lq;
   assign rsp_trade_id          = rpt_ff.tid;
   assign rsp_counter_order_id  = rpt_ff.coid;
   assign rsp_counter_client_id = rpt_ff.ccid;
   assign rsp_last              = rpt_ff.last;

endmodule
